FILE: design/mcbp_pkg.sv
package mcbp_pkg;

  // protocol bytes
  localparam logic [7:0] START_BYTE = 8'h81;
  localparam logic [7:0] CMD_READ   = 8'h52;
  localparam logic [7:0] CMD_WRITE  = 8'h57;
  localparam logic [7:0] REPLY_IDLE = 8'hFF;
  localparam logic [7:0] REPLY_ZERO = 8'h00;
  localparam logic [7:0] REPLY_ID1  = 8'h5A;
  localparam logic [7:0] REPLY_ID2  = 8'h5D;
  localparam logic [7:0] REPLY_ACK1 = 8'h5C;
  localparam logic [7:0] REPLY_GOOD = 8'h47;
  localparam logic [7:0] REPLY_BAD  = 8'h4E;

  // reply source select
  typedef enum logic [3:0] {
    RS_FF,
    RS_LAST,
    RS_ZERO,
    RS_ID1,
    RS_ID2,
    RS_ACK1,
    RS_GOOD,
    RS_BAD,
    RS_BYTE,
    RS_ADDR_HI,
    RS_ADDR_LO,
    RS_XOR,
    RS_MEM
  } rsel_t;

  // controller to datapath commands
  typedef struct packed {
    logic  capture;
    logic  proto_clr;
    logic  cmd_ld;
    logic  addr_hi_ld;
    logic  addr_lo_ld;
    logic  idx_inc;
    logic  idx_clr;
    logic  xor_byte;
    logic  xor_mem;
    logic  sum_ld;
    logic  buf_wr;
    logic  mem_rd;
    logic  copy_start;
    logic  copy_run;
    logic  clear_run;
    logic  out_ld;
    logic  out_ack;
    rsel_t out_sel;
  } mcbp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic deselect;
    logic start_ok;
    logic cmd_read;
    logic cmd_write;
    logic idx0;
    logic idx1;
    logic idx_last;
    logic sum_ok;
    logic in_range;
    logic copy_done;
    logic clear_last;
    logic out_free;
  } mcbp_stat_t;

endpackage

FILE: design/mcbp_dp.sv
module mcbp_dp
  import mcbp_pkg::*;
#(
  parameter int SECTOR_COUNT = 1024,
  parameter int SECTOR_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_tdata,
  input  logic [0:0] in_tuser,
  output logic [7:0] out_tdata,
  output logic [0:0] out_tuser,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  mcbp_cmd_t  cmd,
  output mcbp_stat_t stat
);

  localparam int MemDepth = SECTOR_COUNT * SECTOR_BYTES;
  localparam int Aw       = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int Bw       = (SECTOR_BYTES > 1) ? $clog2(SECTOR_BYTES) : 1;
  localparam logic [7:0]    SecBytes = 8'(SECTOR_BYTES);
  localparam logic [7:0]    IdxLast  = 8'(SECTOR_BYTES - 1);
  localparam logic [16:0]   SecCount = 17'(SECTOR_COUNT);
  localparam logic [Aw-1:0] MemLast  = Aw'(MemDepth - 1);

  // captured transaction
  logic          op_r;
  logic [7:0]    byte_r;
  // protocol registers
  logic [7:0]    cmd_r;
  logic [15:0]   addr_r;
  logic [7:0]    idx_r;
  logic [7:0]    xor_r;
  logic [7:0]    last_r;
  logic [7:0]    sum_r;
  logic [Aw-1:0] base_r;
  logic          in_range_r;
  // memories and their pipelines
  logic [7:0]    mem [MemDepth];
  logic [7:0]    wbuf [SECTOR_BYTES];
  logic [7:0]    mem_q_r;
  logic [7:0]    buf_q_r;
  logic [7:0]    cp_cnt_r;
  logic          cp_wr_r;
  logic [Aw-1:0] cp_addr_r;
  logic [Aw-1:0] clr_addr_r;
  // output register
  logic          out_valid_r;
  logic [7:0]    out_data_r;
  logic          out_ack_r;

  logic [23:0]   base_prod;
  logic [Aw-1:0] rd_addr;
  logic          cp_go;
  logic [7:0]    mem_byte;
  logic [7:0]    rep;

  assign base_prod = {8'd0, addr_r} * {16'd0, SecBytes};
  assign rd_addr   = Aw'(base_r + Aw'(idx_r));
  assign cp_go     = cmd.copy_run && (cp_cnt_r < SecBytes);
  assign mem_byte  = in_range_r ? mem_q_r : REPLY_ZERO;

  // reply select
  always_comb begin
    case (cmd.out_sel)
      RS_FF:      rep = REPLY_IDLE;
      RS_LAST:    rep = last_r;
      RS_ZERO:    rep = REPLY_ZERO;
      RS_ID1:     rep = REPLY_ID1;
      RS_ID2:     rep = REPLY_ID2;
      RS_ACK1:    rep = REPLY_ACK1;
      RS_GOOD:    rep = REPLY_GOOD;
      RS_BAD:     rep = REPLY_BAD;
      RS_BYTE:    rep = byte_r;
      RS_ADDR_HI: rep = addr_r[15:8];
      RS_ADDR_LO: rep = addr_r[7:0];
      RS_XOR:     rep = xor_r;
      RS_MEM:     rep = mem_byte;
      default:    rep = REPLY_IDLE;
    endcase
  end

  // capture of the incoming transaction, plus the checksum byte, sector base and range check
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_tuser[0];
      byte_r <= in_tdata;
    end
    sum_r      <= cmd.sum_ld ? byte_r : sum_r;
    base_r     <= base_prod[Aw-1:0];
    in_range_r <= ({1'b0, addr_r} < SecCount);
  end

  // protocol registers
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.proto_clr) begin
      cmd_r  <= '0;
      addr_r <= '0;
      idx_r  <= '0;
      xor_r  <= '0;
      last_r <= REPLY_IDLE;
    end else begin
      if (cmd.cmd_ld) begin
        cmd_r <= byte_r;
      end
      if (cmd.addr_hi_ld) begin
        addr_r <= {byte_r, 8'h00};
      end
      if (cmd.addr_lo_ld) begin
        addr_r[7:0] <= byte_r;
        xor_r       <= addr_r[15:8] ^ byte_r;
        idx_r       <= '0;
      end else if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 8'd1;
      end
      if (cmd.xor_byte) begin
        xor_r <= xor_r ^ byte_r;
      end else if (cmd.xor_mem) begin
        xor_r <= xor_r ^ mem_byte;
      end
      if (cmd.out_ld) begin
        last_r <= cmd.out_ack ? rep : REPLY_IDLE;
      end
    end
  end

  // card store: clear sweep or commit write, registered read
  always_ff @(posedge clk) begin
    if (cmd.clear_run) begin
      mem[clr_addr_r] <= '0;
    end else if (cp_wr_r) begin
      mem[cp_addr_r] <= buf_q_r;
    end
    if (cmd.mem_rd) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // write buffer
  always_ff @(posedge clk) begin
    if (cmd.buf_wr) begin
      wbuf[idx_r[Bw-1:0]] <= byte_r;
    end
    if (cp_go) begin
      buf_q_r <= wbuf[cp_cnt_r[Bw-1:0]];
    end
  end

  // commit copy and clear sweep counters
  always_ff @(posedge clk) begin
    cp_addr_r <= Aw'(base_r + Aw'(cp_cnt_r));
    if (!rst_n) begin
      cp_cnt_r   <= '0;
      cp_wr_r    <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      cp_wr_r <= cp_go;
      if (cmd.copy_start) begin
        cp_cnt_r <= '0;
      end else if (cp_go) begin
        cp_cnt_r <= cp_cnt_r + 8'd1;
      end
      if (cmd.clear_run) begin
        clr_addr_r <= clr_addr_r + Aw'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_ld) begin
      out_data_r <= cmd.out_ack ? rep : REPLY_IDLE;
      out_ack_r  <= cmd.out_ack;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ack_r;

  // status
  assign stat.deselect   = op_r;
  assign stat.start_ok   = (byte_r == START_BYTE);
  assign stat.cmd_read   = (cmd_r == CMD_READ);
  assign stat.cmd_write  = (cmd_r == CMD_WRITE);
  assign stat.idx0       = (idx_r == 8'd0);
  assign stat.idx1       = (idx_r == 8'd1);
  assign stat.idx_last   = (idx_r == IdxLast);
  assign stat.sum_ok     = (xor_r == sum_r);
  assign stat.in_range   = in_range_r;
  assign stat.copy_done  = (cp_cnt_r == SecBytes) && !cp_wr_r;
  assign stat.clear_last = (clr_addr_r == MemLast);
  assign stat.out_free   = !out_valid_r || out_tready;

endmodule

FILE: design/mcbp_ctrl.sv
module mcbp_ctrl
  import mcbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  mcbp_stat_t stat,
  output mcbp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    SQ_CLEAR,
    SQ_READY,
    SQ_EXEC,
    SQ_RDWAIT,
    SQ_COPY
  } seq_t;

  typedef enum logic [3:0] {
    P_IDLE,
    P_CMD,
    P_CMDACK,
    P_WAIT,
    P_ADDR_HI,
    P_ADDR_LO,
    P_RD_HDR,
    P_RD_DATA,
    P_RD_CHK,
    P_RD_TAIL,
    P_WR_DATA,
    P_WR_SUM,
    P_WR_ACK,
    P_WR_RESULT,
    P_END
  } proto_t;

  seq_t   seq_r, seq_nxt;
  proto_t proto_r, proto_nxt;

  assign in_tready = (seq_r == SQ_READY);

  // sequencing and protocol decode
  always_comb begin
    cmd       = '0;
    cmd.out_sel = RS_FF;
    seq_nxt   = seq_r;
    proto_nxt = proto_r;
    case (seq_r)
      SQ_CLEAR: begin
        cmd.clear_run = 1'b1;
        if (stat.clear_last) begin
          seq_nxt = SQ_READY;
        end
      end
      SQ_READY: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          seq_nxt     = SQ_EXEC;
        end
      end
      SQ_EXEC: begin
        if (stat.out_free) begin
          seq_nxt     = SQ_READY;
          cmd.out_ld  = 1'b1;
          cmd.out_ack = 1'b1;
          if (stat.deselect) begin
            cmd.proto_clr = 1'b1;
            cmd.out_ack   = 1'b0;
            proto_nxt     = P_IDLE;
          end else begin
            case (proto_r)
              P_IDLE: begin
                if (stat.start_ok) begin
                  cmd.out_sel = RS_ZERO;
                  proto_nxt   = P_CMD;
                end else begin
                  cmd.out_ack = 1'b0;
                end
              end
              P_CMD: begin
                cmd.cmd_ld  = 1'b1;
                cmd.out_sel = RS_ID1;
                proto_nxt   = P_CMDACK;
              end
              P_CMDACK: begin
                cmd.out_sel = RS_ID2;
                proto_nxt   = P_WAIT;
              end
              P_WAIT: begin
                cmd.out_sel = RS_ZERO;
                proto_nxt   = P_ADDR_HI;
              end
              P_ADDR_HI: begin
                cmd.addr_hi_ld = 1'b1;
                cmd.out_sel    = RS_BYTE;
                proto_nxt      = P_ADDR_LO;
              end
              P_ADDR_LO: begin
                cmd.addr_lo_ld = 1'b1;
                if (stat.cmd_read) begin
                  cmd.out_sel = RS_ACK1;
                  proto_nxt   = P_RD_HDR;
                end else if (stat.cmd_write) begin
                  cmd.out_sel = RS_BYTE;
                  proto_nxt   = P_WR_DATA;
                end else begin
                  // unknown command repeats the previous reply
                  cmd.out_sel = RS_LAST;
                  proto_nxt   = P_IDLE;
                end
              end
              P_RD_HDR: begin
                if (stat.idx0) begin
                  cmd.out_sel = RS_ID2;
                  cmd.idx_inc = 1'b1;
                end else if (stat.idx1) begin
                  cmd.out_sel = RS_ADDR_HI;
                  cmd.idx_inc = 1'b1;
                end else begin
                  cmd.out_sel = RS_ADDR_LO;
                  cmd.idx_clr = 1'b1;
                  proto_nxt   = P_RD_DATA;
                end
              end
              P_RD_DATA: begin
                // read the store; the reply is loaded from SQ_RDWAIT once the output is free
                cmd.out_ld  = 1'b0;
                cmd.out_ack = 1'b0;
                cmd.mem_rd  = 1'b1;
                seq_nxt     = SQ_RDWAIT;
              end
              P_RD_CHK: begin
                cmd.out_sel = RS_XOR;
                proto_nxt   = P_RD_TAIL;
              end
              P_RD_TAIL: begin
                cmd.out_sel = RS_GOOD;
                proto_nxt   = P_END;
              end
              P_WR_DATA: begin
                cmd.buf_wr   = 1'b1;
                cmd.xor_byte = 1'b1;
                cmd.out_sel  = RS_BYTE;
                if (stat.idx_last) begin
                  cmd.idx_clr = 1'b1;
                  proto_nxt   = P_WR_SUM;
                end else begin
                  cmd.idx_inc = 1'b1;
                end
              end
              P_WR_SUM: begin
                cmd.sum_ld  = 1'b1;
                cmd.out_sel = RS_ACK1;
                proto_nxt   = P_WR_ACK;
              end
              P_WR_ACK: begin
                cmd.out_sel = RS_ID2;
                proto_nxt   = P_WR_RESULT;
              end
              P_WR_RESULT: begin
                proto_nxt = P_END;
                if (stat.sum_ok) begin
                  cmd.out_sel = RS_GOOD;
                  if (stat.in_range) begin
                    cmd.copy_start = 1'b1;
                    seq_nxt        = SQ_COPY;
                  end
                end else begin
                  cmd.out_sel = RS_BAD;
                end
              end
              default: begin
                // end of transaction: drop out and go idle
                cmd.out_ack = 1'b0;
                proto_nxt   = P_IDLE;
              end
            endcase
          end
        end
      end
      SQ_RDWAIT: begin
        if (stat.out_free) begin
          cmd.out_ld  = 1'b1;
          cmd.out_ack = 1'b1;
          cmd.out_sel = RS_MEM;
          cmd.xor_mem = 1'b1;
          seq_nxt     = SQ_READY;
          if (stat.idx_last) begin
            cmd.idx_clr = 1'b1;
            proto_nxt   = P_RD_CHK;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      SQ_COPY: begin
        cmd.copy_run = 1'b1;
        if (stat.copy_done) begin
          seq_nxt = SQ_READY;
        end
      end
      default: begin
        seq_nxt = SQ_READY;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r   <= SQ_CLEAR;
      proto_r <= P_IDLE;
    end else begin
      seq_r   <= seq_nxt;
      proto_r <= proto_nxt;
    end
  end

endmodule

FILE: design/memory_card_byte_protocol.sv
// Card side of a byte-exchange memory card link with a sector store.
// Input stream: one transaction per host byte; in_tdata is the byte, in_tuser
// is 1 for a deselect, which returns the protocol to idle and keeps the store.
// Output stream: one transaction per input; out_tdata is the reply byte for the
// next exchange, out_tuser is the acknowledge flag (reply is 0xFF when low).
// Timing: a byte is captured into a register, and its reply is registered once
// the output register is free; read data bytes are delayed further, since the
// sector store is read through a registered port. The write result byte with a
// good checksum for an in-range sector then copies the sector from the write
// buffer into the store, one byte a cycle, while no input is taken.
// Input is taken one byte at a time; the output register lets the next byte be
// accepted while a reply still waits. A stalled receiver holds the reply and,
// once the following reply is ready, holds the input side too.
// Reset: the protocol goes idle and the store, SECTOR_COUNT * SECTOR_BYTES bytes
// (131072 by default), is swept to zero, one byte a cycle; no input is taken
// during the sweep.
module memory_card_byte_protocol
  import mcbp_pkg::*;
#(
  parameter int SECTOR_COUNT = 1024,
  parameter int SECTOR_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] host_byte
  input  logic [0:0] in_tuser,   // [0] op
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] reply
  output logic [0:0] out_tuser   // [0] acknowledge
);

  mcbp_cmd_t  cmd;
  mcbp_stat_t stat;

  mcbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mcbp_dp #(
    .SECTOR_COUNT (SECTOR_COUNT),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  // no input while the store is swept after reset
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_run |-> !in_tready)
    else $error("input accepted during store clear");

  // no input while a sector commit is copying
  a_copy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.copy_run |-> !in_tready)
    else $error("input accepted during sector commit");

  // a byte is executed before the next one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted back to back");

  // a reply without acknowledge is always 0xFF
  a_nack_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == REPLY_IDLE))
    else $error("unacknowledged reply is not 0xFF");

endmodule

FILE: tb/sv/memory_card_byte_protocol_tb.sv
module memory_card_byte_protocol_tb
  import mcbp_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SECTOR_COUNT = 1024;
  localparam int SECTOR_BYTES = 128;
  localparam int STORE_BYTES  = SECTOR_COUNT * SECTOR_BYTES;
  localparam int TARGET_BYTES = 1750;
  localparam int MAX_REPORTS  = 10;

  // one card answer: reply byte plus acknowledge
  typedef struct packed {
    logic [7:0] reply;
    logic       ack;
  } card_reply_t;

  // card model plus the queue of replies still owed by the block
  class card_scoreboard;
    typedef enum logic [3:0] {
      P_IDLE, P_CMD, P_CMDACK, P_WAIT, P_ADDR_HI, P_ADDR_LO,
      P_RD_HDR, P_RD_DATA, P_RD_CHK, P_RD_TAIL,
      P_WR_DATA, P_WR_SUM, P_WR_ACK, P_WR_RESULT, P_END
    } phase_t;

    phase_t      phase;
    logic [7:0]  command;
    logic [15:0] sector;
    logic [7:0]  index;
    logic [7:0]  checksum;
    logic [7:0]  last_reply;
    logic [7:0]  write_buf [SECTOR_BYTES + 1];
    logic [7:0]  store [STORE_BYTES];
    card_reply_t expected_replies [$];
    int          mismatches;

    function new();
      foreach (store[i]) store[i] = 8'h00;
      foreach (write_buf[i]) write_buf[i] = 8'h00;
      mismatches = 0;
      clear_protocol();
    endfunction

    function void clear_protocol();
      phase      = P_IDLE;
      command    = 8'h00;
      sector     = 16'h0000;
      index      = 8'h00;
      checksum   = 8'h00;
      last_reply = REPLY_IDLE;
    endfunction

    function logic [7:0] stored_byte(int offset);
      if (int'(sector) >= SECTOR_COUNT) return 8'h00;
      return store[int'(sector) * SECTOR_BYTES + offset];
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // advance the card by one host byte and queue the reply it owes
    function void note_byte(logic deselect, logic [7:0] host);
      logic [7:0]  r;
      logic        ok;
      card_reply_t e;
      r  = last_reply;
      ok = 1'b1;
      if (deselect) begin
        clear_protocol();
        e.reply = REPLY_IDLE;
        e.ack   = 1'b0;
        expected_replies.push_back(e);
        return;
      end
      case (phase)
        P_IDLE: begin
          if (host == START_BYTE) begin
            r     = REPLY_ZERO;
            phase = P_CMD;
          end else begin
            ok = 1'b0;
          end
        end
        P_CMD: begin
          command = host;
          r       = REPLY_ID1;
          phase   = P_CMDACK;
        end
        P_CMDACK: begin
          r     = REPLY_ID2;
          phase = P_WAIT;
        end
        P_WAIT: begin
          r     = REPLY_ZERO;
          phase = P_ADDR_HI;
        end
        P_ADDR_HI: begin
          sector = {host, 8'h00};
          r      = host;
          phase  = P_ADDR_LO;
        end
        P_ADDR_LO: begin
          sector[7:0] = host;
          checksum    = sector[15:8] ^ host;
          index       = 8'h00;
          if (command == CMD_READ) begin
            r     = REPLY_ACK1;
            phase = P_RD_HDR;
          end else if (command == CMD_WRITE) begin
            r     = host;
            phase = P_WR_DATA;
          end else begin
            // unknown command: acknowledged, previous reply repeated
            phase = P_IDLE;
          end
        end
        P_RD_HDR: begin
          if (index == 0) r = REPLY_ID2;
          else if (index == 1) r = sector[15:8];
          else r = sector[7:0];
          if (index >= 2) begin
            index = 8'h00;
            phase = P_RD_DATA;
          end else begin
            index++;
          end
        end
        P_RD_DATA: begin
          if (int'(index) >= SECTOR_BYTES) index = 8'h00;
          r        = stored_byte(int'(index));
          checksum ^= r;
          index++;
          if (int'(index) >= SECTOR_BYTES) begin
            index = 8'h00;
            phase = P_RD_CHK;
          end
        end
        P_RD_CHK: begin
          r     = checksum;
          phase = P_RD_TAIL;
        end
        P_RD_TAIL: begin
          r     = REPLY_GOOD;
          phase = P_END;
        end
        P_WR_DATA: begin
          if (int'(index) >= SECTOR_BYTES) index = 8'h00;
          write_buf[index] = host;
          checksum ^= host;
          r = host;
          index++;
          if (int'(index) >= SECTOR_BYTES) begin
            index = 8'h00;
            phase = P_WR_SUM;
          end
        end
        P_WR_SUM: begin
          write_buf[SECTOR_BYTES] = host;
          r     = REPLY_ACK1;
          phase = P_WR_ACK;
        end
        P_WR_ACK: begin
          r     = REPLY_ID2;
          phase = P_WR_RESULT;
        end
        P_WR_RESULT: begin
          // commit only on a matching checksum, and only for a real sector
          if (checksum == write_buf[SECTOR_BYTES]) begin
            if (int'(sector) < SECTOR_COUNT)
              for (int i = 0; i < SECTOR_BYTES; i++)
                store[int'(sector) * SECTOR_BYTES + i] = write_buf[i];
            r = REPLY_GOOD;
          end else begin
            r = REPLY_BAD;
          end
          phase = P_END;
        end
        default: begin
          // end of transaction and unused codes drop out
          ok    = 1'b0;
          phase = P_IDLE;
        end
      endcase
      if (!ok) r = REPLY_IDLE;
      last_reply = r;
      e.reply    = r;
      e.ack      = ok;
      expected_replies.push_back(e);
    endfunction

    // compare one reply transaction with the oldest owed reply
    function void check_reply(logic [7:0] reply, logic ack);
      card_reply_t e;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected reply %02h ack %0d at %0t", reply, ack, $realtime);
        return;
      end
      e = expected_replies.pop_front();
      if (reply !== e.reply || ack !== e.ack) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("reply mismatch at %0t: expected %02h ack %0d, got %02h ack %0d",
                   $realtime, e.reply, e.ack, reply, ack);
      end
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] host_byte
  logic [0:0] in_tuser   = 1'b0;   // [0] op
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] reply
  logic [0:0] out_tuser;           // [0] acknowledge

  card_scoreboard sb;
  int bytes_sent    = 0;
  int in_gap_max    = 9;
  int out_stall_max = 9;

  memory_card_byte_protocol #(
    .SECTOR_COUNT(SECTOR_COUNT),
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // accepted host bytes feed the card model
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_byte(in_tuser[0], in_tdata);
  end

  // accepted replies are checked in order
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_reply(out_tdata, out_tuser[0]);
  end

  // receiver stalls a random number of cycles before each reply
  initial begin
    int stall;
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // one host byte transaction after a random gap
  task automatic send_byte(input logic deselect, input logic [7:0] host);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= host;
    in_tuser  <= deselect;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_byte(1'b0, 8'($urandom_range(0, 255)));
  endtask

  // start byte, command, two fillers, sector high then low
  task automatic send_header(input logic [7:0] command, input logic [15:0] sector);
    send_byte(1'b0, START_BYTE);
    send_byte(1'b0, command);
    send_random(2);
    send_byte(1'b0, sector[15:8]);
    send_byte(1'b0, sector[7:0]);
  endtask

  // header, address echo, data, checksum, tail, then the dropped exchange
  task automatic read_sector(input logic [15:0] sector);
    send_header(CMD_READ, sector);
    send_random(3 + SECTOR_BYTES + 2 + 1);
  endtask

  // data, checksum (good or corrupted), two acks, result, dropped exchange
  task automatic write_sector(input logic [15:0] sector, input logic good);
    logic [7:0] sum;
    logic [7:0] data;
    sum = sector[15:8] ^ sector[7:0];
    send_header(CMD_WRITE, sector);
    repeat (SECTOR_BYTES) begin
      data = 8'($urandom_range(0, 255));
      sum ^= data;
      send_byte(1'b0, data);
    end
    if (!good) sum ^= 8'($urandom_range(1, 255));
    send_byte(1'b0, sum);
    send_random(3);
  endtask

  // a mix of a few busy sectors, random in-range sectors, the edges and out-of-range sectors
  function automatic logic [15:0] pick_sector();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'(SECTOR_COUNT - 1);
      2, 3, 4: return 16'($urandom_range(0, 3));
      5, 6:    return 16'($urandom_range(0, SECTOR_COUNT - 1));
      7:       return ($urandom_range(0, 1) == 0) ? 16'(SECTOR_COUNT) : 16'hFFFF;
      default: return 16'($urandom_range(SECTOR_COUNT, 65535));
    endcase
  endfunction

  initial begin
    int         kind;
    logic [7:0] command;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // deselect while idle, idle bytes that are not a start
    send_byte(1'b1, 8'hFF);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h80);
    // unknown commands at the address extremes, then idle again
    send_header(8'hFF, 16'hFFFF);
    send_byte(1'b0, 8'h7E);
    send_header(8'h00, 16'h0000);
    send_byte(1'b1, START_BYTE);
    // deselect in the middle of a write
    send_byte(1'b0, START_BYTE);
    send_byte(1'b0, CMD_WRITE);
    send_byte(1'b1, 8'h00);

    // edge sectors: written then read back, in range and out of range
    write_sector(16'(SECTOR_COUNT - 1), 1'b1);
    read_sector(16'(SECTOR_COUNT - 1));
    write_sector(16'hFFFF, 1'b1);
    read_sector(16'hFFFF);

    // random transactions, mostly well formed
    while (bytes_sent < TARGET_BYTES) begin
      in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 9;
      out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        write_sector(pick_sector(), 1'b1);
      end else if (kind < 50) begin
        write_sector(pick_sector(), 1'b0);
      end else if (kind < 85) begin
        read_sector(pick_sector());
      end else if (kind < 90) begin
        // unknown command, a few idle bytes, then resync
        do command = 8'($urandom_range(0, 255));
        while (command == CMD_READ || command == CMD_WRITE);
        send_header(command, pick_sector());
        send_random($urandom_range(0, 3));
        send_byte(1'b1, 8'($urandom_range(0, 255)));
      end else if (kind < 95) begin
        // transaction cut short by a deselect
        send_header(($urandom_range(0, 1) == 0) ? CMD_READ : CMD_WRITE, pick_sector());
        send_random($urandom_range(0, SECTOR_BYTES + 7));
        send_byte(1'b1, 8'($urandom_range(0, 255)));
      end else begin
        // line noise, then resync
        repeat ($urandom_range(1, 8))
          send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        send_byte(1'b1, 8'($urandom_range(0, 255)));
      end
    end
    in_tvalid <= 1'b0;

    // drain, then leave room for a sector commit
    while (sb.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("memory_card_byte_protocol_tb passed");
    end else begin
      $display("memory_card_byte_protocol_tb failed");
    end
    $finish;
  end

  // watchdog: covers the store sweep after reset and a slow run many times over
  initial begin
    #20_000_000;
    $display("memory_card_byte_protocol_tb failed");
    $finish;
  end

endmodule

FILE: filelist.f
design/mcbp_pkg.sv
design/mcbp_dp.sv
design/mcbp_ctrl.sv
design/memory_card_byte_protocol.sv
tb/sv/memory_card_byte_protocol_tb.sv
